// ----- sv/sip24_pkg.sv -----
package sip24_pkg;

	// initialization constants
	localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
	localparam logic [63:0] SIP_C1 = 64'h646f72616e646f6d;
	localparam logic [63:0] SIP_C2 = 64'h6c7967656e657261;
	localparam logic [63:0] SIP_C3 = 64'h7465646279746573;
	localparam logic [63:0] FINAL_FOLD = 64'h00000000000000ff;

	// register indexes of the configuration port
	localparam logic CFG_KEY_LOW = 1'b0;
	localparam logic CFG_KEY_HIGH = 1'b1;

	// half-round counts: two rounds per block, four in finalization
	localparam logic [2:0] ABSORB_LAST_HALF = 3'd3;
	localparam logic [2:0] FINAL_LAST_HALF = 3'd7;

	localparam logic [3:0] FULL_BYTES = 4'd8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ABSORB,
		ST_FINAL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] c;
		logic [63:0] d;
	} sip_state_t;

	function automatic logic [63:0] rotl64(input logic [63:0] x, input int r);
		rotl64 = (x << r) | (x >> (64 - r));
	endfunction

endpackage

// ----- sv/siphash_2_4_engine_top.sv -----
// channel   direction  handshake            payload
// in        input      in_valid/in_ready    message_word, valid_bytes, last_word
// cfg       input      cfg_valid/cfg_ready  cfg_index, cfg_data
// out       output     out_valid/out_ready  digest
//
// One shared half-round unit (two 64-bit adders) runs one half SipRound per cycle.
// A word that is not last runs two SipRounds as four half rounds, then returns to idle.
// A full last word adds one more block that holds only the length byte; every last word
// then gets four SipRounds of finalization and a load of the digest.
// The digest sits in an output register; a following item is accepted while it waits,
// and only the next digest stalls until the previous one is taken.
// Reset clears keys, length count and control; no clearing pass.
module siphash_2_4_engine_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] message_word,
	input  logic [3:0]  valid_bytes,
	input  logic        last_word,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] digest
);

	sip24_pkg::state_t state_q, state_d;

	logic [63:0] key_low_q, key_high_q;
	sip24_pkg::sip_state_t v_q, v_d;
	logic [63:0] m_q, m_d;
	logic [7:0]  len_q, len_d;
	logic [2:0]  cnt_q, cnt_d;
	logic        in_msg_q, in_msg_d;
	logic        extra_q, extra_d;
	logic        last_q, last_d;
	logic        out_valid_q, out_valid_d;
	logic [63:0] digest_q, digest_d;

	// input decode
	logic [3:0]  nb_sat;
	logic [7:0]  len_base, len_new;
	logic [63:0] len_block, len_block_q, word_mask, first_block;
	sip24_pkg::sip_state_t v_start;

	// shared half-round unit
	logic [63:0] add1, add2;
	sip24_pkg::sip_state_t hr;

	assign in_ready  = (state_q == sip24_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign digest    = digest_q;

	// key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == sip24_pkg::CFG_KEY_LOW) begin
				key_low_q <= cfg_data;
			end else begin
				key_high_q <= cfg_data;
			end
		end
	end

	// length, mask and first block of an incoming word
	always_comb begin
		nb_sat    = (valid_bytes > sip24_pkg::FULL_BYTES) ? sip24_pkg::FULL_BYTES : valid_bytes;
		len_base  = in_msg_q ? len_q : 8'd0;
		if (last_word) begin
			len_new = len_base + {4'd0, nb_sat};
		end else begin
			len_new = len_base + {4'd0, sip24_pkg::FULL_BYTES};
		end
		len_block = {len_new, 56'd0};
		for (int i = 0; i < 8; i++) begin
			word_mask[i*8 +: 8] = (4'(i) < nb_sat) ? 8'hff : 8'h00;
		end
		if (!last_word || nb_sat == sip24_pkg::FULL_BYTES) begin
			first_block = message_word;
		end else begin
			first_block = (message_word & word_mask) | len_block;
		end
		if (in_msg_q) begin
			v_start = v_q;
		end else begin
			v_start.a = key_low_q ^ sip24_pkg::SIP_C0;
			v_start.b = key_high_q ^ sip24_pkg::SIP_C1;
			v_start.c = key_low_q ^ sip24_pkg::SIP_C2;
			v_start.d = key_high_q ^ sip24_pkg::SIP_C3;
		end
	end

	// half round: even count is the first half, odd count the second
	always_comb begin
		add1 = v_q.a + (cnt_q[0] ? v_q.d : v_q.b);
		add2 = v_q.c + (cnt_q[0] ? v_q.b : v_q.d);
		if (!cnt_q[0]) begin
			hr.a = sip24_pkg::rotl64(add1, 32);
			hr.b = sip24_pkg::rotl64(v_q.b, 13) ^ add1;
			hr.c = add2;
			hr.d = sip24_pkg::rotl64(v_q.d, 16) ^ add2;
		end else begin
			hr.a = add1;
			hr.d = sip24_pkg::rotl64(v_q.d, 21) ^ add1;
			hr.c = sip24_pkg::rotl64(add2, 32);
			hr.b = sip24_pkg::rotl64(v_q.b, 17) ^ add2;
		end
	end

	// sequencer
	always_comb begin
		state_d     = state_q;
		v_d         = v_q;
		m_d         = m_q;
		len_d       = len_q;
		cnt_d       = cnt_q;
		in_msg_d    = in_msg_q;
		extra_d     = extra_q;
		last_d      = last_q;
		out_valid_d = out_valid_q;
		digest_d    = digest_q;
		if (out_valid_q && out_ready) begin
			out_valid_d = 1'b0;
		end
		case (state_q)
			sip24_pkg::ST_IDLE: begin
				if (in_valid) begin
					v_d       = v_start;
					v_d.d     = v_start.d ^ first_block;
					m_d       = first_block;
					len_d     = len_new;
					in_msg_d  = 1'b1;
					last_d    = last_word;
					extra_d   = last_word && (nb_sat == sip24_pkg::FULL_BYTES);
					cnt_d     = '0;
					state_d   = sip24_pkg::ST_ABSORB;
				end
			end
			sip24_pkg::ST_ABSORB: begin
				v_d   = hr;
				cnt_d = cnt_q + 3'd1;
				if (cnt_q == sip24_pkg::ABSORB_LAST_HALF) begin
					v_d.a = hr.a ^ m_q;
					cnt_d = '0;
					if (extra_q) begin
						// full last word: one more block with only the length byte
						m_d     = len_block_q;
						v_d.d   = hr.d ^ len_block_q;
						extra_d = 1'b0;
					end else if (last_q) begin
						v_d.c   = hr.c ^ sip24_pkg::FINAL_FOLD;
						state_d = sip24_pkg::ST_FINAL;
					end else begin
						state_d = sip24_pkg::ST_IDLE;
					end
				end
			end
			sip24_pkg::ST_FINAL: begin
				v_d   = hr;
				cnt_d = cnt_q + 3'd1;
				if (cnt_q == sip24_pkg::FINAL_LAST_HALF) begin
					state_d = sip24_pkg::ST_DONE;
				end
			end
			sip24_pkg::ST_DONE: begin
				// wait for the output register to be free
				if (!out_valid_q || out_ready) begin
					digest_d    = v_q.a ^ v_q.b ^ v_q.c ^ v_q.d;
					out_valid_d = 1'b1;
					in_msg_d    = 1'b0;
					len_d       = '0;
					state_d     = sip24_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sip24_pkg::ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sip24_pkg::ST_IDLE;
			cnt_q       <= '0;
			len_q       <= '0;
			in_msg_q    <= 1'b0;
			extra_q     <= 1'b0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			len_q       <= len_d;
			in_msg_q    <= in_msg_d;
			extra_q     <= extra_d;
			last_q      <= last_d;
			out_valid_q <= out_valid_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		v_q      <= v_d;
		m_q      <= m_d;
		digest_q <= digest_d;
		if (in_ready && in_valid) begin
			len_block_q <= len_block;
		end
	end

endmodule
